>>> design/erbd_pkg.sv
`timescale 1ns / 1ps

package erbd_pkg;

    // Build-time defaults for the top-level parameters
    localparam int DIVISOR_DEFAULT   = 4;
    localparam int MAX_WIDTH_DEFAULT = 8192;

    // Stream payload widths
    localparam int PIXEL_W     = 32;
    localparam int AVG_W       = 25;
    localparam int OUT_TDATA_W = 32;

    // Configuration port
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 24;
    localparam int SRC_WIDTH_W = 14;
    localparam int SCALE_W     = 24;
    localparam int OFFSET_W    = 24;

    localparam logic [CFG_ADDR_W-1:0] REG_SOURCE_WIDTH    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ELEVATION_SCALE = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BEACH_OFFSET    = 2'd2;

    localparam int                 SRC_WIDTH_RESET = 1024;
    localparam logic [SCALE_W-1:0] SCALE_RESET     = 24'd256;
    localparam logic [OFFSET_W-1:0] OFFSET_RESET   = 24'd0;

    // Q0.24 height fraction
    localparam int                FRAC_W    = 24;
    localparam logic [FRAC_W:0]   FRAC_ONE  = 25'h100_0000;
    localparam logic [7:0]        EXP_NONFINITE = 8'hFF;
    localparam logic [7:0]        EXP_ONE       = 8'd127;
    localparam logic [7:0]        EXP_HALF      = 8'd126;

    // Finite single -> Q0.24 in [0, 1.0]; negatives (and -0) go to zero,
    // anything at or above one saturates, the rest truncates.
    function automatic logic [FRAC_W:0] pixel_fraction(input logic [PIXEL_W-1:0] bits);
        logic [7:0]        expo;
        logic [FRAC_W-1:0] mant;
        logic [7:0]        sh;
        logic [FRAC_W:0]   p;
        expo = bits[30:23];
        mant = (expo != 8'd0) ? {1'b1, bits[22:0]} : {1'b0, bits[22:0]};
        sh   = EXP_HALF - ((expo != 8'd0) ? expo : 8'd1);
        if (bits[31]) begin
            p = '0;
        end else if (expo >= EXP_ONE) begin
            p = FRAC_ONE;
        end else if (sh >= 8'd24) begin
            p = '0;
        end else begin
            p = {1'b0, mant >> sh[4:0]};
        end
        return p;
    endfunction

endpackage

>>> design/elevation_remap_box_downsample.sv
// Path from an accepted pixel word to m_tvalid: stages 1-4, the finished-sum register and the
//   output queue, plus 1 + ceil((SUM_W+1)/8) divider stages when DIVISOR is not a power of two.
// Throughput: one pixel word per cycle while the output queue has room, set by the block-sum RAM
//   read-modify-write (read in stage 3, write in stage 4, last write forwarded).
// Reset (aresetn, synchronous, active low): counters, pipeline valids, output queue and
//   registers return to defaults; the block-sum RAM is not cleared, a block's first pixel
//   overwrites its entry.
`timescale 1ns / 1ps

module elevation_remap_box_downsample
    import erbd_pkg::*;
#(
    parameter int DIVISOR   = DIVISOR_DEFAULT,
    parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // pixel words
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [PIXEL_W-1:0]     s_tdata,   // [31:0] pixel_bits
    // averaged words
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [24:0] height_average, [31:25] zero
    output logic                   m_tlast,   // frame_last
    // register writes
    input  logic                   cfg_wen,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    // ---------------------------------------------------------------------
    // Derived sizes
    // ---------------------------------------------------------------------
    localparam int SLOTS  = MAX_WIDTH / DIVISOR;          // blocks per row at most
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int Q_W    = $clog2(SLOTS + 1);
    localparam int DX_W   = $clog2(DIVISOR);
    localparam int WID_W  = $clog2(MAX_WIDTH + 1);
    localparam int CW     = (WID_W > SRC_WIDTH_W) ? WID_W : SRC_WIDTH_W;
    localparam int AREA   = DIVISOR * DIVISOR;
    localparam int SUM_W  = AVG_W + $clog2(AREA);
    localparam bit AREA_POW2 = ((AREA & (AREA - 1)) == 0);

    localparam logic [DX_W-1:0] DX_LAST = DX_W'(DIVISOR - 1);

    // source_width -> blocks per row, by reciprocal multiply (exact below 2^CW)
    localparam int             QSH   = CW + $clog2(DIVISOR);
    localparam logic [63:0]    RECIP64 =
        ((64'd1 << QSH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [CW:0]    RECIP = RECIP64[CW:0];

    localparam int Q_RST_RAW =
        ((SRC_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : SRC_WIDTH_RESET) / DIVISOR;
    localparam int Q_RST     = (Q_RST_RAW < 1) ? 1 : Q_RST_RAW;

    localparam logic [1:0] FIFO_FULL = 2'd2;

    // ---------------------------------------------------------------------
    // Configuration registers. Width is kept as a block count and its last index.
    // ---------------------------------------------------------------------
    logic [Q_W-1:0]      blocks_reg;
    logic [SLOT_W-1:0]   block_last_reg;
    logic [SCALE_W-1:0]  elevation_scale_reg;
    logic [OFFSET_W-1:0] beach_offset_reg;

    logic [CW-1:0]   sw_ext;
    logic [CW-1:0]   sw_clamped;
    logic [2*CW:0]   q_prod;
    logic [Q_W-1:0]  q_calc;
    logic [Q_W-1:0]  q_fixed;

    assign sw_ext     = CW'(cfg_wdata[SRC_WIDTH_W-1:0]);
    assign sw_clamped = (sw_ext > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : sw_ext;
    assign q_prod     = (2*CW+1)'(sw_clamped) * (2*CW+1)'(RECIP);
    assign q_calc     = Q_W'(q_prod >> QSH);
    assign q_fixed    = (q_calc == '0) ? Q_W'(1) : q_calc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blocks_reg          <= Q_W'(Q_RST);
            block_last_reg      <= SLOT_W'(Q_RST - 1);
            elevation_scale_reg <= SCALE_RESET;
            beach_offset_reg    <= OFFSET_RESET;
        end else if (cfg_wen) begin
            case (cfg_addr)
                REG_SOURCE_WIDTH: begin
                    blocks_reg     <= q_fixed;
                    block_last_reg <= SLOT_W'(q_fixed - Q_W'(1));
                end
                REG_ELEVATION_SCALE: elevation_scale_reg <= cfg_wdata[SCALE_W-1:0];
                REG_BEACH_OFFSET:    beach_offset_reg    <= cfg_wdata[OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Global advance: the whole pipe moves while the output queue has room.
    // ---------------------------------------------------------------------
    logic [1:0] fifo_cnt_reg;
    logic       adv;
    logic       accept;

    assign adv      = (fifo_cnt_reg != FIFO_FULL);
    assign s_tready = adv;
    assign accept   = s_tvalid && adv;

    // ---------------------------------------------------------------------
    // Raster position: block column/row plus offset inside the block.
    // Counters past a shrunk width read as zero.
    // ---------------------------------------------------------------------
    logic [SLOT_W-1:0] bcol_reg, brow_reg;
    logic [DX_W-1:0]   dx_reg, dy_reg;

    logic              col_over, row_over;
    logic [SLOT_W-1:0] bcol_eff, brow_eff;
    logic [DX_W-1:0]   dx_eff, dy_eff;
    logic              row_end, frame_end;
    logic              pos_first, pos_emit;

    assign col_over  = (Q_W'(bcol_reg) >= blocks_reg);
    assign row_over  = (Q_W'(brow_reg) >= blocks_reg);
    assign bcol_eff  = col_over ? '0 : bcol_reg;
    assign dx_eff    = col_over ? '0 : dx_reg;
    assign brow_eff  = row_over ? '0 : brow_reg;
    assign dy_eff    = row_over ? '0 : dy_reg;

    assign row_end   = (bcol_eff == block_last_reg) && (dx_eff == DX_LAST);
    assign frame_end = (brow_eff == block_last_reg) && (dy_eff == DX_LAST);
    assign pos_first = (dx_eff == '0) && (dy_eff == '0);
    assign pos_emit  = (dx_eff == DX_LAST) && (dy_eff == DX_LAST);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bcol_reg <= '0;
            brow_reg <= '0;
            dx_reg   <= '0;
            dy_reg   <= '0;
        end else if (accept) begin
            if (row_end) begin
                bcol_reg <= '0;
                dx_reg   <= '0;
                if (frame_end) begin
                    brow_reg <= '0;
                    dy_reg   <= '0;
                end else if (dy_eff == DX_LAST) begin
                    brow_reg <= brow_eff + SLOT_W'(1);
                    dy_reg   <= '0;
                end else begin
                    brow_reg <= brow_eff;
                    dy_reg   <= dy_eff + DX_W'(1);
                end
            end else begin
                brow_reg <= brow_eff;
                dy_reg   <= dy_eff;
                if (dx_eff == DX_LAST) begin
                    bcol_reg <= bcol_eff + SLOT_W'(1);
                    dx_reg   <= '0;
                end else begin
                    bcol_reg <= bcol_eff;
                    dx_reg   <= dx_eff + DX_W'(1);
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Stage 1: float decode -> (1 - p), zero for Inf/NaN so h = -offset
    // Stage 2: multiply by scale
    // Stage 3: subtract offset, issue RAM read of the block slot
    // Stage 4: accumulate, write back, hand finished blocks to the divider
    // ---------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic [PIXEL_W-1:0] pix1_reg;
    logic [SLOT_W-1:0]  slot1_reg, slot2_reg, slot3_reg, slot4_reg;
    logic first1_reg, first2_reg, first3_reg, first4_reg;
    logic emit1_reg, emit2_reg, emit3_reg, emit4_reg;
    logic flast1_reg, flast2_reg, flast3_reg, flast4_reg;

    logic [FRAC_W:0]     factor1;
    logic [FRAC_W:0]     factor2_reg;
    logic [FRAC_W+SCALE_W:0] prod2;
    logic [SCALE_W-1:0]  prod3_reg;
    logic signed [AVG_W-1:0] h3;
    logic signed [AVG_W-1:0] h4_reg;

    assign factor1 = (pix1_reg[30:23] == EXP_NONFINITE) ? '0
                   : (FRAC_ONE - pixel_fraction(pix1_reg));
    assign prod2   = (FRAC_W+SCALE_W+1)'(factor2_reg)
                   * (FRAC_W+SCALE_W+1)'(elevation_scale_reg);
    assign h3      = $signed({1'b0, prod3_reg}) - $signed({1'b0, beach_offset_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pix1_reg    <= s_tdata;
            slot1_reg   <= bcol_eff;
            first1_reg  <= pos_first;
            emit1_reg   <= pos_emit;
            flast1_reg  <= pos_emit && row_end && frame_end;

            factor2_reg <= factor1;
            slot2_reg   <= slot1_reg;
            first2_reg  <= first1_reg;
            emit2_reg   <= emit1_reg;
            flast2_reg  <= flast1_reg;

            prod3_reg   <= prod2[FRAC_W +: SCALE_W];
            slot3_reg   <= slot2_reg;
            first3_reg  <= first2_reg;
            emit3_reg   <= emit2_reg;
            flast3_reg  <= flast2_reg;

            h4_reg      <= h3;
            slot4_reg   <= slot3_reg;
            first4_reg  <= first3_reg;
            emit4_reg   <= emit3_reg;
            flast4_reg  <= flast3_reg;
        end
    end

    // Block-sum RAM. Neighboring pixels share a slot, so the write made at the
    // same edge as the next read is forwarded from a side register.
    logic [SUM_W-1:0]        ram_rdata;
    logic                    ram_we;
    logic signed [SUM_W-1:0] base4;
    logic signed [SUM_W-1:0] sum4;
    logic                    fwd_valid_reg;
    logic [SLOT_W-1:0]       fwd_slot_reg;
    logic [SUM_W-1:0]        fwd_sum_reg;
    logic                    fwd_hit;

    assign ram_we  = adv && v4_reg;
    assign fwd_hit = fwd_valid_reg && (fwd_slot_reg == slot4_reg);
    assign base4   = first4_reg ? '0
                   : (fwd_hit ? $signed(fwd_sum_reg) : $signed(ram_rdata));
    assign sum4    = base4 + {{(SUM_W-AVG_W){h4_reg[AVG_W-1]}}, h4_reg};

    erbd_ram #(
        .WIDTH (SUM_W),
        .DEPTH (SLOTS)
    ) u_block_sums (
        .clk     (aclk),
        .wr_en   (ram_we),
        .wr_addr (slot4_reg),
        .wr_data (sum4),
        .rd_en   (adv),
        .rd_addr (slot3_reg),
        .rd_data (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_valid_reg <= 1'b0;
        end else if (ram_we) begin
            fwd_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ram_we) begin
            fwd_slot_reg <= slot4_reg;
            fwd_sum_reg  <= sum4;
        end
    end

    // Finished block sum
    logic             rs_valid_reg;
    logic [SUM_W-1:0] rs_sum_reg;
    logic             rs_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rs_valid_reg <= 1'b0;
        end else if (adv) begin
            rs_valid_reg <= v4_reg && emit4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rs_sum_reg  <= sum4;
            rs_last_reg <= flast4_reg;
        end
    end

    // ---------------------------------------------------------------------
    // Floor division by DIVISOR^2
    // ---------------------------------------------------------------------
    logic             res_valid;
    logic [AVG_W-1:0] res_avg;
    logic             res_last;

    generate
        if (AREA_POW2) begin : g_shift
            localparam int NL = $clog2(AREA);
            logic signed [SUM_W-1:0] shifted;

            // arithmetic shift floors toward minus infinity
            assign shifted   = $signed(rs_sum_reg) >>> NL;
            assign res_valid = rs_valid_reg;
            assign res_avg   = shifted[AVG_W-1:0];
            assign res_last  = rs_last_reg;
        end else begin : g_divide
            // Bias to a non-negative value, long-divide 8 bits per stage,
            // then remove the bias from the quotient.
            localparam int BPS = 8;
            localparam int UW  = SUM_W + 1;
            localparam int NST = (UW + BPS - 1) / BPS;
            localparam int PW  = NST * BPS;
            localparam int RW  = $clog2(AREA) + 1;
            localparam logic [63:0] C_OFF64 =
                ((64'd1 << (SUM_W - 1)) + 64'(AREA) - 64'd1) / 64'(AREA);
            localparam logic [63:0] OFF64   = C_OFF64 * 64'(AREA);
            localparam logic [PW-1:0] C_OFF = C_OFF64[PW-1:0];
            localparam logic [PW-1:0] BIAS  = OFF64[PW-1:0];

            logic [PW-1:0]   dv_num_reg  [0:NST];
            logic [RW-2:0]   dv_rem_reg  [0:NST];
            logic            dv_valid_reg[0:NST];
            logic            dv_last_reg [0:NST];
            logic [PW-1:0]   dv_num_next [1:NST];
            logic [RW-2:0]   dv_rem_next [1:NST];
            logic [PW-1:0]   quotient;

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    dv_valid_reg[0] <= 1'b0;
                end else if (adv) begin
                    dv_valid_reg[0] <= rs_valid_reg;
                end
            end

            always_ff @(posedge aclk) begin
                if (adv) begin
                    dv_num_reg[0]  <= {{(PW-SUM_W){rs_sum_reg[SUM_W-1]}}, rs_sum_reg} + BIAS;
                    dv_rem_reg[0]  <= '0;
                    dv_last_reg[0] <= rs_last_reg;
                end
            end

            for (genvar k = 1; k <= NST; k++) begin : g_stage
                always_comb begin : div_steps
                    logic [PW-1:0] n;
                    logic [RW-1:0] t;
                    logic [RW-2:0] r;
                    n = dv_num_reg[k-1];
                    r = dv_rem_reg[k-1];
                    for (int j = 0; j < BPS; j++) begin
                        t = {r, n[PW-1]};
                        n = {n[PW-2:0], 1'b0};
                        if (t >= RW'(AREA)) begin
                            t    = t - RW'(AREA);
                            n[0] = 1'b1;
                        end
                        r = t[RW-2:0];
                    end
                    dv_num_next[k] = n;
                    dv_rem_next[k] = r;
                end

                always_ff @(posedge aclk) begin
                    if (!aresetn) begin
                        dv_valid_reg[k] <= 1'b0;
                    end else if (adv) begin
                        dv_valid_reg[k] <= dv_valid_reg[k-1];
                    end
                end

                always_ff @(posedge aclk) begin
                    if (adv) begin
                        dv_num_reg[k]  <= dv_num_next[k];
                        dv_rem_reg[k]  <= dv_rem_next[k];
                        dv_last_reg[k] <= dv_last_reg[k-1];
                    end
                end
            end

            assign quotient  = dv_num_reg[NST] - C_OFF;
            assign res_valid = dv_valid_reg[NST];
            assign res_avg   = quotient[AVG_W-1:0];
            assign res_last  = dv_last_reg[NST];
        end
    endgenerate

    // ---------------------------------------------------------------------
    // Two-word output queue: keeps taking pixels while a result waits.
    // ---------------------------------------------------------------------
    logic [AVG_W-1:0] fifo_avg_reg  [2];
    logic             fifo_last_reg [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic             push, pop;

    assign push     = adv && res_valid;
    assign m_tvalid = (fifo_cnt_reg != 2'd0);
    assign pop      = m_tvalid && m_tready;
    assign m_tdata  = OUT_TDATA_W'(fifo_avg_reg[rd_ptr_reg]);
    assign m_tlast  = fifo_last_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fifo_cnt_reg <= '0;
            wr_ptr_reg   <= 1'b0;
            rd_ptr_reg   <= 1'b0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                fifo_cnt_reg <= fifo_cnt_reg + 2'd1;
            end else if (pop && !push) begin
                fifo_cnt_reg <= fifo_cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_avg_reg[wr_ptr_reg]  <= res_avg;
            fifo_last_reg[wr_ptr_reg] <= res_last;
        end
    end

    // ---------------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------------
    a_queue_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (fifo_cnt_reg != FIFO_FULL))
        else $error("output queue written while full");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && fifo_cnt_reg == FIFO_FULL))
        else $error("input stalled with room in output queue");

    a_first_not_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        v4_reg |-> !(first4_reg && emit4_reg))
        else $error("block opened and closed on one pixel");

    a_frame_last_on_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && flast1_reg) |-> emit1_reg)
        else $error("frame end flagged on a non-closing pixel");

endmodule

>>> design/erbd_ram.sv
`timescale 1ns / 1ps

module erbd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> dv/tb_elevation_remap_box_downsample.sv
`timescale 1ns / 1ps

module tb_elevation_remap_box_downsample;
    import erbd_pkg::*;

    localparam int          DIV           = DIVISOR_DEFAULT;
    localparam int          BOX_AREA      = DIV * DIV;
    localparam int          SLOTS         = MAX_WIDTH_DEFAULT / DIV;
    localparam int          IDLE_PCT      = 15;    // idle chance per cycle, each side
    localparam int          HOLD_CYCLES   = 600;   // long m_tready hold-off
    localparam int          SETTLE_CYCLES = 32;    // longer than the pipeline latency
    localparam int          RANDOM_PIXELS = 900;
    localparam longint      TIMEOUT_NS    = 64'd4_000_000;

    // Directed pixels, one 4x4 frame: signed zeros, one and just below it,
    // huge finite values, denormals, the 2^-24 step, infinities and NaNs.
    localparam logic [PIXEL_W-1:0] SPECIAL_PIXELS [BOX_AREA] = '{
        32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'h3F00_0000,
        32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h0000_0001, 32'h007F_FFFF,
        32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'hFFFF_FFFF,
        32'h3F7F_FFFF, 32'h0080_0000, 32'h3380_0000, 32'h3300_0000
    };

    typedef struct packed {
        logic [AVG_W-1:0] avg;
        logic             last;
    } block_avg_t;

    // ---------------------------------------------------------------
    // DUT hookup; every input starts at a known value
    // ---------------------------------------------------------------
    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [PIXEL_W-1:0]     s_tdata   = '0;    // [31:0] pixel_bits
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;           // [24:0] height_average, [31:25] zero
    logic                   m_tlast;           // frame_last
    logic                   cfg_wen   = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    elevation_remap_box_downsample dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #10 aclk = ~aclk;

    // ---------------------------------------------------------------
    // Box-average predictor: own copy of registers, raster position
    // and the per-slot running sums of the current block row
    // ---------------------------------------------------------------
    logic [SRC_WIDTH_W-1:0] cfg_width;
    logic [SCALE_W-1:0]     cfg_scale;
    logic [OFFSET_W-1:0]    cfg_offset;
    int unsigned            col_pos;
    int unsigned            row_pos;
    longint                 slot_sum [SLOTS];

    block_avg_t  expected_avgs [$];
    block_avg_t  got_want;
    int unsigned mismatch_count = 0;
    int unsigned pixel_count    = 0;
    bit          steady_flow    = 1'b0;   // both sides stream without gaps
    bit          hold_request   = 1'b0;   // receiver starts a long hold-off

    // side clamped to MAX_WIDTH, floored to a DIV multiple, at least DIV
    function automatic int unsigned eff_width();
        int unsigned w;
        w = cfg_width;
        if (w > MAX_WIDTH_DEFAULT) w = MAX_WIDTH_DEFAULT;
        w -= w % DIV;
        if (w < DIV) w = DIV;
        return w;
    endfunction

    // counters at or past the side count as zero at the next pixel
    function automatic bit at_frame_start();
        int unsigned w;
        w = eff_width();
        return (col_pos == 0 || col_pos >= w) && (row_pos == 0 || row_pos >= w);
    endfunction

    function automatic void predict_pixel(input logic [PIXEL_W-1:0] bits);
        int unsigned     w, c, r, slot;
        logic [7:0]      expo;
        logic [FRAC_W-1:0] mant;
        int              sh;
        longint          frac, h, acc, avg;
        block_avg_t      word;
        w = eff_width();
        if (col_pos >= w) col_pos = 0;
        if (row_pos >= w) row_pos = 0;
        c    = col_pos;
        r    = row_pos;
        slot = c / DIV;

        // remap: Inf/NaN -> -offset, else (1-p)*scale - offset
        expo = bits[30:23];
        if (expo == EXP_NONFINITE) begin
            h = -longint'(cfg_offset);
        end else begin
            if (bits[31]) begin
                frac = 0;
            end else if (expo >= EXP_ONE) begin
                frac = longint'(FRAC_ONE);
            end else begin
                mant = {(expo != 8'd0), bits[22:0]};
                sh   = int'(EXP_HALF) - ((expo != 8'd0) ? int'(expo) : 1);
                frac = (sh >= FRAC_W) ? 0 : longint'(mant >> sh);
            end
            h = (((longint'(FRAC_ONE) - frac) * longint'(cfg_scale)) >>> FRAC_W)
                - longint'(cfg_offset);
        end

        // first pixel of a block restarts the slot
        if ((c % DIV) == 0 && (r % DIV) == 0) acc = h;
        else acc = slot_sum[slot] + h;
        slot_sum[slot] = acc;

        if ((c % DIV) == DIV - 1 && (r % DIV) == DIV - 1) begin
            // floor division, toward minus infinity
            avg = (acc >= 0) ? acc / BOX_AREA : -((-acc + BOX_AREA - 1) / BOX_AREA);
            word.avg  = avg[AVG_W-1:0];
            word.last = (c == w - 1) && (r == w - 1);
            expected_avgs.push_back(word);
        end

        if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (r + 1 >= w) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic logic [PIXEL_W-1:0] random_pixel();
        logic [31:0] raw;
        raw = $urandom;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return {1'b0, 8'($urandom_range(100, 126)), raw[22:0]};  // (0,1)
            4:          return raw;
            5:          return {1'b1, raw[30:0]};                                // negative
            6:          return {1'b0, 8'($urandom_range(127, 254)), raw[22:0]};  // >= 1
            7:          return {1'b0, 8'($urandom_range(0, 103)), raw[22:0]};    // tiny
            8:          return {raw[31], EXP_NONFINITE, raw[22:0]};
            default:    return raw[0] ? {raw[31], 31'h0} : {1'b0, EXP_ONE, 23'h0};
        endcase
    endfunction

    // all three registers, back to back, block idle
    task automatic write_regs(input logic [CFG_DATA_W-1:0] width_word,
                              input logic [CFG_DATA_W-1:0] scale_word,
                              input logic [CFG_DATA_W-1:0] offset_word);
        cfg_wen   <= 1'b1;
        cfg_addr  <= REG_SOURCE_WIDTH;
        cfg_wdata <= width_word;
        @(posedge aclk);
        cfg_addr  <= REG_ELEVATION_SCALE;
        cfg_wdata <= scale_word;
        @(posedge aclk);
        cfg_addr  <= REG_BEACH_OFFSET;
        cfg_wdata <= offset_word;
        @(posedge aclk);
        cfg_wen   <= 1'b0;
        cfg_width  = width_word[SRC_WIDTH_W-1:0];
        cfg_scale  = scale_word[SCALE_W-1:0];
        cfg_offset = offset_word[OFFSET_W-1:0];
    endtask

    // one pixel word; valid stays up across back-to-back words
    task automatic send_pixel(input logic [PIXEL_W-1:0] bits);
        while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= bits;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_pixel(bits);
        pixel_count++;
    endtask

    // whole frames of random pixels, ending on a frame boundary
    task automatic send_frames(input int unsigned frames);
        int unsigned w, target, sent;
        w      = eff_width();
        target = frames * w * w;
        sent   = 0;
        while (sent < target || !at_frame_start()) begin
            send_pixel(random_pixel());
            sent++;
        end
    endtask

    // drop valid, wait out expected words, then the pipeline tail
    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_avgs.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // width 0 gives a 4x4 raster: one word covering the directed corner-case pixels
    task automatic test_special_pixels();
        write_regs(24'd0, 24'hFF_FFFF, 24'd0);
        foreach (SPECIAL_PIXELS[i]) send_pixel(SPECIAL_PIXELS[i]);
        settle();
    endtask

    // all-ones width clamps to MAX_WIDTH; only a partial first row, no words.
    // The next width write folds the column back to the frame start.
    task automatic test_wide_raster();
        write_regs(24'h00_3FFF, 24'h12_3456, 24'h00_FFFF);
        repeat (2 * DIV) send_pixel(random_pixel());
        settle();
    endtask

    // gapless stretch on both sides
    task automatic test_steady_stream();
        steady_flow = 1'b1;
        write_regs(24'd8, 24'hFF_FFFF, 24'($urandom_range(0, 24'hFF_FFFF)));
        send_frames(2);
        settle();
        steady_flow = 1'b0;
    endtask

    // receiver holds off while pixels keep coming, so s_tready must drop
    task automatic test_backpressure();
        write_regs(24'd16, 24'($urandom), 24'($urandom));
        hold_request = 1'b1;
        send_frames(3);
        settle();
    endtask

    // random phases: width, scale, offset (incl. offset above scale), frames
    task automatic test_random_frames();
        int unsigned start, phase, w;
        logic [SCALE_W-1:0]  scale;
        logic [OFFSET_W-1:0] offset;
        logic [CFG_DATA_W-1:0] width_word;
        start = pixel_count;
        phase = 0;
        while (pixel_count < start + RANDOM_PIXELS) begin
            w = DIV * (($urandom_range(0, 7) == 0) ? 5 : $urandom_range(1, 4));
            // junk above the 14-bit field, sometimes a non-multiple width
            width_word = {10'($urandom), SRC_WIDTH_W'(w + $urandom_range(0, DIV - 1))};
            case (phase % 4)
                0: begin
                    scale  = 24'($urandom);
                    offset = 24'($urandom_range(0, scale));
                end
                1: begin
                    scale  = '1;
                    offset = '0;
                end
                2: begin
                    scale  = '0;
                    offset = '1;
                end
                default: begin
                    scale  = 24'($urandom);
                    offset = 24'($urandom);
                end
            endcase
            write_regs(width_word, scale, offset);
            send_frames($urandom_range(1, 2));
            settle();
            phase++;
        end
    endtask

    // ---------------------------------------------------------------
    // Receiver: random m_tready, long hold-off counted here on request
    // ---------------------------------------------------------------
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                m_tready <= 1'b0;
                for (int stall = 1; stall < HOLD_CYCLES; stall++) @(posedge aclk);
                hold_request = 1'b0;
            end else if (steady_flow) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // ---------------------------------------------------------------
    // Checker: each accepted word against the oldest expectation
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_avgs.size() == 0) begin
                $error("unexpected averaged word: tdata %h tlast %b", m_tdata, m_tlast);
                mismatch_count++;
            end else begin
                got_want = expected_avgs.pop_front();
                if (m_tdata[AVG_W-1:0] !== got_want.avg) begin
                    $error("height_average: expected %0d, got %0d",
                           $signed(got_want.avg), $signed(m_tdata[AVG_W-1:0]));
                    mismatch_count++;
                end
                if (m_tdata[OUT_TDATA_W-1:AVG_W] !== '0) begin
                    $error("tdata pad: expected 0, got %h", m_tdata[OUT_TDATA_W-1:AVG_W]);
                    mismatch_count++;
                end
                if (m_tlast !== got_want.last) begin
                    $error("frame_last: expected %b, got %b", got_want.last, m_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        cfg_width  = SRC_WIDTH_W'(SRC_WIDTH_RESET);
        cfg_scale  = SCALE_RESET;
        cfg_offset = OFFSET_RESET;
        col_pos    = 0;
        row_pos    = 0;
        foreach (slot_sum[i]) slot_sum[i] = 0;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        test_special_pixels();
        test_wide_raster();
        test_steady_stream();
        test_backpressure();
        test_random_frames();

        settle();
        if (mismatch_count == 0) begin
            $display("PASS elevation_remap_box_downsample");
        end else begin
            $display("FAIL elevation_remap_box_downsample");
        end
        $finish;
    end

    // hang guard
    initial begin
        #(TIMEOUT_NS);
        $display("FAIL elevation_remap_box_downsample");
        $finish;
    end

endmodule

>>> elevation_remap_box_downsample.f
design/erbd_pkg.sv
design/erbd_ram.sv
design/elevation_remap_box_downsample.sv
dv/tb_elevation_remap_box_downsample.sv
